@@ src/bitmap_attribute_cell_renderer_top_assert.svh @@
// Assertion macros used by the checker of the renderer.
`ifndef BITMAP_ATTRIBUTE_CELL_RENDERER_TOP_ASSERT_SVH
`define BITMAP_ATTRIBUTE_CELL_RENDERER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BACR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("renderer check failed");

// The consequent must hold in the cycle after the antecedent.
`define BACR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("renderer check failed");

`endif

@@ src/bacr_pkg.sv @@
package bacr_pkg;

	localparam int BMP_DEPTH          = 6144;
	localparam int ATTR_DEPTH         = 768;
	localparam int STORE_DEPTH        = BMP_DEPTH + ATTR_DEPTH;
	localparam int BMP_AW             = $clog2(BMP_DEPTH);
	localparam int ATTR_AW            = $clog2(ATTR_DEPTH);
	localparam int FIRST_SHOWN_LINE   = 40;
	localparam int LAST_SHOWN_LINE    = 279;
	localparam int FIRST_PICTURE_LINE = 64;
	localparam int PICTURE_LINES      = 192;
	localparam int FIRST_PICTURE_COL  = 4;
	localparam int PICTURE_COLS       = 32;
	localparam int TOTAL_COLS         = 40;
	localparam int FLASH_FRAMES       = 16;
	localparam int FRAME_W            = $clog2(FLASH_FRAMES + 1);

	localparam logic [7:0] BORDER_PORT  = 8'hFE;
	localparam logic [2:0] BORDER_RESET = 3'd7;

	typedef enum logic [1:0] {
		ACT_STORE_WRITE = 2'd0,
		ACT_PORT_WRITE  = 2'd1,
		ACT_FRAME_TICK  = 2'd2,
		ACT_RENDER      = 2'd3
	} bacr_action_t;

	typedef struct packed {
		bacr_action_t action;
		logic [12:0]  store_address;
		logic [7:0]   data;
		logic [7:0]   port_low;
		logic [8:0]   scanline;
		logic [5:0]   cell_column;
	} bacr_cmd_t;

	typedef struct packed {
		logic        valid_res;
		logic [23:0] pixels;
	} bacr_res_t;

	typedef struct packed {
		logic              bmp_en;
		logic [BMP_AW-1:0] bmp_addr;
		logic              att_en;
		logic [ATTR_AW-1:0] att_addr;
		logic [7:0]        data;
	} bacr_store_wr_t;

	typedef struct packed {
		logic               en;
		logic [BMP_AW-1:0]  bmp_addr;
		logic [ATTR_AW-1:0] att_addr;
	} bacr_store_rd_t;

	function automatic logic [23:0] fill_cell(logic [2:0] colour);
		logic [23:0] acc;
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			acc[3*i +: 3] = colour;
		end
		return acc;
	endfunction

	function automatic logic [23:0] picture_cell(logic [7:0] bits, logic [7:0] att,
			logic flash);
		logic [2:0]  fore;
		logic [2:0]  back;
		logic [23:0] acc;
		fore = att[2:0];
		back = att[5:3];
		if (att[7] && flash) begin
			fore = att[5:3];
			back = att[2:0];
		end
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			acc[3*i +: 3] = bits[7-i] ? fore : back;
		end
		return acc;
	endfunction

endpackage

@@ src/bacr_store.sv @@
module bacr_store
	import bacr_pkg::*;
(
	input  logic           clk,
	input  bacr_store_wr_t wr,
	input  bacr_store_rd_t rd,
	output logic [7:0]     bmp_q,
	output logic [7:0]     att_q
);

	logic [7:0] bmp_mem [BMP_DEPTH];
	logic [7:0] att_mem [ATTR_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.bmp_en) begin
			bmp_mem[wr.bmp_addr] <= wr.data;
		end
		if (rd.en) begin
			bmp_q <= bmp_mem[rd.bmp_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.att_en) begin
			att_mem[wr.att_addr] <= wr.data;
		end
		if (rd.en) begin
			att_q <= att_mem[rd.att_addr];
		end
	end

endmodule

@@ src/bitmap_attribute_cell_renderer_top.sv @@
// Cell renderer over a 6144-byte bitmap and a 768-byte attribute store. Every command
// transaction (store write, border port write, frame tick or cell render) returns exactly one
// result transaction, in order. Commands are taken one per cycle when the result side keeps
// up. A render reads the bitmap byte and the attribute byte from their two memories in the
// cycle of acceptance; the pixels are composed from the registered read data and pass into
// the output register when stage 1 advances. Up to two results may be in flight. After
// reset the stores are cleared by a pass of one bitmap byte a cycle over all 6144 bitmap
// addresses, with one attribute byte a cycle for the first 768, while cmd_stall stays high.
module bitmap_attribute_cell_renderer_top
	import bacr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  bacr_cmd_t cmd,
	output logic      res_valid,
	input  logic      res_stall,
	output bacr_res_t res
);

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} state_t;

	state_t             state_q;
	logic [BMP_AW-1:0]  clr_cnt_q;
	logic [2:0]         border_q;
	logic [FRAME_W-1:0] frame_q;
	logic               flash_q;

	logic               valid_s1;
	logic               shown_s1;
	logic               pict_s1;
	logic [2:0]         border_s1;
	logic               flash_s1;

	logic               res_valid_q;
	bacr_res_t          res_q;

	logic               cmd_acc;
	logic               out_free;
	logic               s1_adv;
	logic               shown;
	logic               pict;
	logic [8:0]         y_full;
	logic [7:0]         y;
	logic [5:0]         col_off;
	logic [4:0]         pcol;
	logic [7:0]         bmp_rd;
	logic [7:0]         att_rd;
	bacr_store_wr_t     wr;
	bacr_store_rd_t     rd;
	bacr_res_t          res_d;

	assign out_free  = !res_valid_q || !res_stall;
	assign s1_adv    = valid_s1 && out_free;
	assign cmd_stall = (state_q != ST_RUN) || (valid_s1 && !out_free);
	assign cmd_acc   = cmd_valid && !cmd_stall;

	assign shown = (cmd.scanline >= 9'(FIRST_SHOWN_LINE))
		&& (cmd.scanline <= 9'(LAST_SHOWN_LINE))
		&& (cmd.cell_column < 6'(TOTAL_COLS));
	assign pict = (cmd.scanline >= 9'(FIRST_PICTURE_LINE))
		&& (cmd.scanline < 9'(FIRST_PICTURE_LINE + PICTURE_LINES))
		&& (cmd.cell_column >= 6'(FIRST_PICTURE_COL))
		&& (cmd.cell_column < 6'(FIRST_PICTURE_COL + PICTURE_COLS));

	assign y_full  = cmd.scanline - 9'(FIRST_PICTURE_LINE);
	assign y       = y_full[7:0];
	assign col_off = cmd.cell_column - 6'(FIRST_PICTURE_COL);
	assign pcol    = col_off[4:0];

	always_comb begin
		wr = '0;
		rd = '0;
		rd.bmp_addr = {y[7:6], y[2:0], y[5:3], pcol};
		rd.att_addr = {y[7:3], pcol};
		if (state_q == ST_CLEAR) begin
			wr.bmp_en   = 1'b1;
			wr.bmp_addr = clr_cnt_q;
			wr.att_en   = clr_cnt_q < BMP_AW'(ATTR_DEPTH);
			wr.att_addr = clr_cnt_q[ATTR_AW-1:0];
			wr.data     = '0;
		end else if (cmd_acc) begin
			unique case (cmd.action)
				ACT_STORE_WRITE: begin
					wr.data     = cmd.data;
					wr.bmp_addr = cmd.store_address;
					wr.att_addr = ATTR_AW'(cmd.store_address - 13'(BMP_DEPTH));
					if (cmd.store_address < 13'(BMP_DEPTH)) begin
						wr.bmp_en = 1'b1;
					end else if (cmd.store_address < 13'(STORE_DEPTH)) begin
						wr.att_en = 1'b1;
					end
				end
				ACT_RENDER: begin
					rd.en = pict;
				end
				default: begin
				end
			endcase
		end
	end

	bacr_store u_store (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.bmp_q (bmp_rd),
		.att_q (att_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == BMP_AW'(BMP_DEPTH - 1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_q <= BORDER_RESET;
			frame_q  <= '0;
			flash_q  <= 1'b0;
		end else if (cmd_acc) begin
			if (cmd.action == ACT_PORT_WRITE && cmd.port_low == BORDER_PORT) begin
				border_q <= cmd.data[2:0];
			end
			if (cmd.action == ACT_FRAME_TICK) begin
				if (frame_q >= FRAME_W'(FLASH_FRAMES)) begin
					frame_q <= FRAME_W'(1);
					flash_q <= !flash_q;
				end else begin
					frame_q <= frame_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			shown_s1  <= (cmd.action == ACT_RENDER) && shown;
			pict_s1   <= pict;
			border_s1 <= border_q;
			flash_s1  <= flash_q;
		end
	end

	always_comb begin
		res_d = '0;
		if (shown_s1) begin
			res_d.valid_res = 1'b1;
			res_d.pixels    = pict_s1 ? picture_cell(bmp_rd, att_rd, flash_s1)
				: fill_cell(border_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= 1'b1;
		end else if (out_free) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ src/bacr_checker.sv @@
`include "bitmap_attribute_cell_renderer_top_assert.svh"

module bacr_checker
	import bacr_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_stall,
	input bacr_cmd_t cmd,
	input logic      res_valid,
	input logic      res_stall,
	input bacr_res_t res
);

	logic [1:0] pending_q;
	logic       cmd_acc;
	logic       res_acc;

	assign cmd_acc = cmd_valid && !cmd_stall;
	assign res_acc = res_valid && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(cmd_acc) - 2'(res_acc);
		end
	end

	`BACR_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res))

	`BACR_ASSERT_NOW(a_res_has_cmd, clk, arst_n, res_valid, pending_q != 2'd0)

	`BACR_ASSERT_NOW(a_no_overrun, clk, arst_n, cmd_acc && pending_q == 2'd2, res_acc)

	`BACR_ASSERT_NOW(a_idle_no_res, clk, arst_n, pending_q == 2'd0, !res_valid)

endmodule

bind bitmap_attribute_cell_renderer_top bacr_checker u_bacr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import bacr_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int RANDOM_ITEMS = 1550;
	localparam int HOT_CELLS    = 8;

	typedef struct {
		bacr_cmd_t c;
		int        reps;
		bit        typed;
		bacr_res_t want;
	} row_t;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	bacr_cmd_t cmd;
	logic      res_valid;
	logic      res_stall;
	bacr_res_t res;

	logic [7:0] shadow_store [STORE_DEPTH];
	logic [2:0] shadow_border;
	int         shadow_frames;
	logic       shadow_flash;

	bacr_res_t pending_cells[$];
	row_t      directed_rows[$];
	int        hot_line [HOT_CELLS];
	int        hot_col [HOT_CELLS];

	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;
	int cycles;
	int commands_sent;
	int renders;
	int shown_renders;
	int swapped_renders;
	int results_checked;

	bitmap_attribute_cell_renderer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still awaited.", cycles,
				pending_cells.size());
			$display("tb NOT OK");
			$finish;
		end
	end

	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic bacr_cmd_t scrambled_cmd();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[$bits(bacr_cmd_t)-1:0];
	endfunction

	function automatic void cell_offsets(input int line, input int col, output int bmp,
			output int att);
		int y;
		int x;
		int row;
		y = line - FIRST_PICTURE_LINE;
		x = col - FIRST_PICTURE_COL;
		row = (y & 'hC0) | ((y & 'h38) >> 3) | ((y & 'h07) << 3);
		bmp = (row << 5) + x;
		att = BMP_DEPTH + ((y >> 3) << 5) + x;
	endfunction

	// Applies one command to the shadow state and returns the cell it should produce.
	function automatic bacr_res_t render_step(bacr_cmd_t c);
		bacr_res_t r;
		int bmp;
		int att;
		logic [7:0] bits;
		logic [7:0] attr;
		logic [2:0] ink;
		logic [2:0] paper;
		r = '0;
		case (c.action)
			ACT_STORE_WRITE: begin
				if (c.store_address < STORE_DEPTH)
					shadow_store[c.store_address] = c.data;
			end
			ACT_PORT_WRITE: begin
				if (c.port_low == BORDER_PORT)
					shadow_border = c.data[2:0];
			end
			ACT_FRAME_TICK: begin
				if (shadow_frames >= FLASH_FRAMES) begin
					shadow_frames = 0;
					shadow_flash = ~shadow_flash;
				end
				shadow_frames++;
			end
			ACT_RENDER: begin
				renders++;
				if (c.scanline >= FIRST_SHOWN_LINE && c.scanline <= LAST_SHOWN_LINE
						&& c.cell_column < TOTAL_COLS) begin
					shown_renders++;
					r.valid_res = 1'b1;
					if (c.scanline >= FIRST_PICTURE_LINE
							&& c.scanline < FIRST_PICTURE_LINE + PICTURE_LINES
							&& c.cell_column >= FIRST_PICTURE_COL
							&& c.cell_column < FIRST_PICTURE_COL + PICTURE_COLS) begin
						cell_offsets(c.scanline, c.cell_column, bmp, att);
						bits = shadow_store[bmp];
						attr = shadow_store[att];
						ink = attr[2:0];
						paper = attr[5:3];
						if (attr[7] && shadow_flash) begin
							swapped_renders++;
							ink = attr[5:3];
							paper = attr[2:0];
						end
						for (int i = 0; i < 8; i++)
							r.pixels[3*i +: 3] = bits[7-i] ? ink : paper;
					end else begin
						for (int i = 0; i < 8; i++)
							r.pixels[3*i +: 3] = shadow_border;
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic void add_row(bacr_action_t a, int addr, int dat, int port, int line,
			int col, int reps, bit typed, bit v, logic [23:0] pix);
		row_t w;
		w.c.action = a;
		w.c.store_address = addr[12:0];
		w.c.data = dat[7:0];
		w.c.port_low = port[7:0];
		w.c.scanline = line[8:0];
		w.c.cell_column = col[5:0];
		w.reps = reps;
		w.typed = typed;
		w.want.valid_res = v;
		w.want.pixels = pix;
		directed_rows.insert(directed_rows.size(), w);
	endfunction

	// Mostly well-formed traffic: store writes and renders aimed at a few hot picture cells,
	// border writes to the border port, and frame ticks frequent enough to flip flash often.
	function automatic bacr_cmd_t random_command();
		bacr_cmd_t c;
		int k;
		int sel;
		int h;
		int bmp;
		int att;
		c = scrambled_cmd();
		k = $urandom_range(99);
		h = $urandom_range(HOT_CELLS - 1);
		cell_offsets(hot_line[h], hot_col[h], bmp, att);
		if (k < 45) begin
			c.action = ACT_RENDER;
			sel = $urandom_range(9);
			if (sel < 6) begin
				c.scanline = 9'(hot_line[h]);
				c.cell_column = 6'(hot_col[h]);
			end else if (sel < 8) begin
				c.scanline = 9'($urandom_range(LAST_SHOWN_LINE, FIRST_SHOWN_LINE));
				c.cell_column = 6'($urandom_range(TOTAL_COLS - 1));
			end
		end else if (k < 75) begin
			c.action = ACT_STORE_WRITE;
			sel = $urandom_range(9);
			if (sel < 4)
				c.store_address = 13'(bmp);
			else if (sel < 7)
				c.store_address = 13'(att);
		end else if (k < 90) begin
			c.action = ACT_FRAME_TICK;
		end else begin
			c.action = ACT_PORT_WRITE;
			if ($urandom_range(9) < 6)
				c.port_low = BORDER_PORT;
		end
		return c;
	endfunction

	task automatic send_command(input bacr_cmd_t c, input bit typed, input bacr_res_t want);
		bacr_res_t got;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			cmd <= scrambled_cmd();
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		got = render_step(c);
		pending_cells.insert(pending_cells.size(), typed ? want : got);
		commands_sent++;
		@(negedge clk);
	endtask

	task automatic report_mismatch(input string what, input bacr_res_t want,
			input bacr_res_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected valid_res %0b pixels %06h, got valid_res %0b pixels %06h",
				$realtime, what, want.valid_res, want.pixels, got.valid_res, got.pixels);
	endtask

	always @(posedge clk) begin : check_results
		bacr_res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_cells.size() == 0) begin
				report_mismatch("result with no command outstanding", '0, res);
			end else begin
				want = pending_cells.pop_front();
				results_checked++;
				if (res.valid_res !== want.valid_res || res.pixels !== want.pixels)
					report_mismatch("result mismatch", want, res);
			end
		end
	end

	initial begin : stimulus
		bacr_res_t none;
		none = '0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		res_stall = 1'b0;
		cycles = 0;
		mismatches = 0;
		commands_sent = 0;
		renders = 0;
		shown_renders = 0;
		swapped_renders = 0;
		results_checked = 0;
		for (int i = 0; i < STORE_DEPTH; i++)
			shadow_store[i] = 8'h00;
		shadow_border = BORDER_RESET;
		shadow_frames = 0;
		shadow_flash = 1'b0;
		send_idle_pct = 6;
		recv_stall_pct = 56;

		add_row(ACT_RENDER, 0, 0, 0, 40, 0, 1, 1, 1, 24'hFFFFFF);
		add_row(ACT_RENDER, 0, 0, 0, 64, 4, 1, 1, 1, 24'h000000);
		add_row(ACT_RENDER, 0, 0, 0, 39, 0, 1, 1, 0, 24'h000000);
		add_row(ACT_RENDER, 0, 0, 0, 280, 20, 1, 1, 0, 24'h000000);
		add_row(ACT_RENDER, 8191, 255, 255, 511, 63, 1, 1, 0, 24'h0);
		add_row(ACT_RENDER, 0, 0, 0, 100, 40, 1, 1, 0, 24'h000000);
		add_row(ACT_RENDER, 0, 0, 0, 0, 0, 1, 1, 0, 24'h000000);
		add_row(ACT_PORT_WRITE, 0, 'h07, 'hFD, 0, 0, 1, 1, 0, 24'h0);
		add_row(ACT_PORT_WRITE, 0, 'hFA, 'hFE, 0, 0, 1, 1, 0, 24'h0);
		add_row(ACT_RENDER, 0, 0, 0, 279, 39, 1, 1, 1, 24'h492492);
		add_row(ACT_RENDER, 0, 0, 0, 100, 3, 1, 0, 0, 24'h0);
		add_row(ACT_RENDER, 0, 0, 0, 63, 36, 1, 0, 0, 24'h0);
		add_row(ACT_STORE_WRITE, 0, 'hFF, 0, 0, 0, 1, 1, 0, 24'h0);
		add_row(ACT_STORE_WRITE, 6144, 'h8A, 0, 0, 0, 1, 1, 0, 24'h0);
		add_row(ACT_RENDER, 0, 0, 0, 64, 4, 1, 0, 0, 24'h0);
		add_row(ACT_STORE_WRITE, 6143, 'h81, 0, 0, 0, 1, 1, 0, 24'h0);
		add_row(ACT_STORE_WRITE, 6911, 'hBD, 0, 0, 0, 1, 1, 0, 24'h0);
		add_row(ACT_RENDER, 0, 0, 0, 255, 35, 1, 0, 0, 24'h0);
		add_row(ACT_STORE_WRITE, 6912, 'h55, 0, 0, 0, 1, 1, 0, 24'h0);
		add_row(ACT_STORE_WRITE, 8191, 'hAA, 0, 0, 0, 1, 1, 0, 24'h0);
		add_row(ACT_RENDER, 0, 0, 0, 256, 10, 1, 0, 0, 24'h0);
		add_row(ACT_FRAME_TICK, 0, 0, 0, 0, 0, 17, 1, 0, 24'h0);
		add_row(ACT_RENDER, 0, 0, 0, 64, 4, 1, 0, 0, 24'h0);
		add_row(ACT_RENDER, 0, 0, 0, 255, 35, 1, 0, 0, 24'h0);
		add_row(ACT_STORE_WRITE, 6144, 'h0A, 0, 0, 0, 1, 1, 0, 24'h0);
		add_row(ACT_RENDER, 0, 0, 0, 64, 4, 1, 0, 0, 24'h0);
		add_row(ACT_PORT_WRITE, 0, 0, 0, 0, 0, 1, 1, 0, 24'h0);

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			repeat (directed_rows[i].reps)
				send_command(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);

		for (int h = 0; h < HOT_CELLS; h++) begin
			hot_line[h] = FIRST_PICTURE_LINE + $urandom_range(PICTURE_LINES - 1);
			hot_col[h] = FIRST_PICTURE_COL + $urandom_range(PICTURE_COLS - 1);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				send_idle_pct = 56;
				recv_stall_pct = 6;
			end else if (n == 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			send_command(random_command(), 1'b0, none);
		end
		cmd_valid <= 1'b0;

		while (pending_cells.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Sent %0d commands, %0d of them cell renders (%0d on shown lines,", commands_sent,
			renders, shown_renders);
		$display("%0d with ink and paper swapped); %0d results compared, %0d mismatches.",
			swapped_renders, results_checked, mismatches);
		if (mismatches == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+src
src/bacr_pkg.sv
src/bacr_store.sv
src/bitmap_attribute_cell_renderer_top.sv
src/bacr_checker.sv
verif/tb.sv
